@@ design/lv3d_pkg.sv @@
// shared types and constants of the 3d local variance stencil
// no dependencies
`default_nettype none

package lv3d_pkg;

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  localparam int unsigned SIZE_MIN = 3;

  // log2 of the in-column weight (dy, dz) for tap dy*3+dz
  localparam int unsigned W_SHIFT [9] = '{0, 1, 0, 1, 2, 1, 0, 1, 0};

  typedef struct packed {
    logic shift;
    logic load_a;
    logic load_b;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ design/lv3d_cell.sv @@
// one stencil column cell: nine window samples, their squares and weighted sums
// depends on lv3d_pkg
`default_nettype none

module lv3d_cell import lv3d_pkg::*; #(
  parameter int SB = 16
) (
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic [9*SB-1:0]   col_in,
  output logic [9*SB-1:0]        col_out,
  output logic signed [SB+3:0]   sum_f,
  output logic [2*SB+3:0]        sum_q
);

  logic signed [SB-1:0]   smp_r [9];
  logic [2*SB-1:0]        sq_r [9];
  logic signed [SB+3:0]   wf_a_r;
  logic signed [SB+3:0]   wf_b_r;
  logic [2*SB+3:0]        wq_b_r;
  logic signed [SB+3:0]   wf_nxt;
  logic [2*SB+3:0]        wq_nxt;

  always_comb begin
    wf_nxt = '0;
    wq_nxt = '0;
    for (int i = 0; i < 9; i++) begin
      wf_nxt = wf_nxt + ((SB+4)'(smp_r[i]) <<< W_SHIFT[i]);
      wq_nxt = wq_nxt + ((2*SB+4)'(sq_r[i]) << W_SHIFT[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      if (ctl.shift) begin
        smp_r[i] <= col_in[i*SB +: SB];
      end
      if (ctl.load_a) begin
        sq_r[i] <= (2*SB)'(smp_r[i] * smp_r[i]);
      end
    end
    if (ctl.load_a) begin
      wf_a_r <= wf_nxt;
    end
    if (ctl.load_b) begin
      wf_b_r <= wf_a_r;
      wq_b_r <= wq_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      col_out[i*SB +: SB] = smp_r[i];
    end
  end

  assign sum_f = wf_b_r;
  assign sum_q = wq_b_r;

endmodule

`default_nettype wire

@@ design/local_variance_3d_stencil.sv @@
// top level: raster position, plane and line stores, three-cell window, variance
// depends on lv3d_pkg and lv3d_cell
// each interior sample word yields a result through the stage and output registers
// throughput: one sample word per clock while not stalled by out_ready; plane store read and written once per word
// reset (synchronous, rst_n low): sizes 64, position zero, pipeline empty
// store contents are not cleared; a result never uses an entry its grid has not written
`default_nettype none

module local_variance_3d_stencil import lv3d_pkg::*; #(
  parameter int MAX_X       = 64,
  parameter int MAX_Y       = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [21:0]      out_mean_scaled,
  output logic [42:0]             out_variance_scaled,
  output logic                    out_last_cell,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int RW    = (SB > 16) ? SB : 16;
  localparam int XA    = $clog2(MAX_X);
  localparam int YA    = $clog2(MAX_Y);
  localparam int XS    = $clog2(MAX_X + 1);
  localparam int YS    = $clog2(MAX_Y + 1);
  localparam int DEPTH = MAX_X * MAX_Y;
  localparam int ADW   = $clog2(DEPTH);
  localparam int MW    = SB + 6;
  localparam int QW    = 2 * SB + 6;
  localparam int VW    = 2 * SB + 12;

  // configuration and position
  logic [6:0]     size_x_r, size_y_r;
  logic [15:0]    size_z_r;
  logic [XA-1:0]  pos_x_r;
  logic [YA-1:0]  pos_y_r;
  logic [15:0]    pos_z_r;
  logic [XS-1:0]  sx;
  logic [YS-1:0]  sy;
  logic [15:0]    sz;
  logic [XS-1:0]  x_inc;
  logic [YS-1:0]  y_inc;
  logic [16:0]    z_inc;
  logic           in_acc, cfg_acc;
  logic           interior0, last0;
  logic [ADW-1:0] addr0;
  logic [RW-1:0]  raw;
  logic signed [SB-1:0] samp0;

  // pipeline control
  logic [6:1] v_r, lst_r;
  logic [7:1] free;
  logic [6:0] mv;
  logic       int1_r;

  // stage 1
  logic signed [SB-1:0] samp1_r;
  logic [ADW-1:0]       addr1_r;
  logic [XA-1:0]        x1_r;
  logic                 par1_r;
  logic [2*SB-1:0]      pm_rd_r;
  logic [3*SB-1:0]      lb0_rd_r, lb1_rd_r;
  logic [2*SB-1:0]      pm [DEPTH];
  logic [3*SB-1:0]      lb0 [MAX_X];
  logic [3*SB-1:0]      lb1 [MAX_X];
  logic [3*SB-1:0]      col_cur, col_old, col_mid;
  logic [9*SB-1:0]      col_new;

  // cells and arithmetic
  cell_ctl_t            ctl;
  logic [9*SB-1:0]      col_in [3];
  logic [9*SB-1:0]      col_out [3];
  logic signed [SB+3:0] sum_f [3];
  logic [2*SB+3:0]      sum_q [3];
  logic signed [MW-1:0] mean5_r, mean6_r;
  logic [QW-1:0]        sq5_r, sq6_r;
  logic signed [2*MW-1:0] msq_r;
  logic [VW-1:0]        var_nxt;
  logic signed [63:0]   mean_w;
  logic [63:0]          var_w;
  logic                 out_valid_r;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;

  always_comb begin
    if (size_x_r < 7'(SIZE_MIN)) sx = XS'(SIZE_MIN);
    else if (size_x_r > MAX_X)    sx = XS'(MAX_X);
    else                          sx = XS'(size_x_r);
    if (size_y_r < 7'(SIZE_MIN)) sy = YS'(SIZE_MIN);
    else if (size_y_r > MAX_Y)    sy = YS'(MAX_Y);
    else                          sy = YS'(size_y_r);
    if (size_z_r < 16'(SIZE_MIN)) sz = 16'(SIZE_MIN);
    else                          sz = size_z_r;
  end

  assign raw   = RW'($unsigned(in_sample));
  assign samp0 = raw[SB-1:0];
  assign x_inc = XS'(pos_x_r) + XS'(1);
  assign y_inc = YS'(pos_y_r) + YS'(1);
  assign z_inc = 17'(pos_z_r) + 17'd1;
  assign addr0 = ADW'(pos_y_r) * ADW'(MAX_X) + ADW'(pos_x_r);
  assign interior0 = (pos_x_r >= XA'(2)) && (pos_y_r >= YA'(2)) && (pos_z_r >= 16'd2);
  assign last0 = (XS'(pos_x_r) == sx - XS'(1)) && (YS'(pos_y_r) == sy - YS'(1))
              && (pos_z_r == sz - 16'd1);

  // stage enables, from the output back
  always_comb begin
    free[7] = !out_valid_r || out_ready;
    for (int k = 6; k >= 1; k--) begin
      free[k] = !v_r[k] || free[k+1];
    end
    mv[0] = in_valid && free[1];
    for (int k = 1; k <= 6; k++) begin
      mv[k] = v_r[k] && free[k+1];
    end
  end

  assign in_ready = free[1];
  assign in_acc   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r    <= 7'd64;
      size_y_r    <= 7'd64;
      size_z_r    <= 16'd64;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      pos_z_r     <= '0;
      v_r         <= '0;
      lst_r       <= '0;
      int1_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index)
          REG_SIZE_X: size_x_r <= cfg_data[6:0];
          REG_SIZE_Y: size_y_r <= cfg_data[6:0];
          REG_SIZE_Z: size_z_r <= cfg_data;
          default: ;
        endcase
        if (cfg_index == REG_SIZE_X || cfg_index == REG_SIZE_Y ||
            cfg_index == REG_SIZE_Z) begin
          pos_x_r <= '0;
          pos_y_r <= '0;
          pos_z_r <= '0;
        end
      end else if (in_acc) begin
        if (x_inc >= sx) begin
          pos_x_r <= '0;
          if (y_inc >= sy) begin
            pos_y_r <= '0;
            pos_z_r <= (z_inc >= 17'(sz)) ? 16'd0 : z_inc[15:0];
          end else begin
            pos_y_r <= y_inc[YA-1:0];
          end
        end else begin
          pos_x_r <= x_inc[XA-1:0];
        end
      end
      if (free[1]) begin
        v_r[1]   <= mv[0];
        lst_r[1] <= last0;
        int1_r   <= interior0;
      end
      if (free[2]) begin
        v_r[2]   <= mv[1] && int1_r;
        lst_r[2] <= lst_r[1];
      end
      for (int k = 3; k <= 6; k++) begin
        if (free[k]) begin
          v_r[k]   <= mv[k-1];
          lst_r[k] <= lst_r[k-1];
        end
      end
      if (free[7]) begin
        out_valid_r <= v_r[6];
      end
    end
  end

  // stores: read on accept, read-modify-write when the word leaves stage 1
  always_ff @(posedge clk) begin
    if (mv[0]) begin
      samp1_r  <= samp0;
      addr1_r  <= addr0;
      x1_r     <= pos_x_r;
      par1_r   <= pos_y_r[0];
      pm_rd_r  <= pm[addr0];
      lb0_rd_r <= lb0[pos_x_r];
      lb1_rd_r <= lb1[pos_x_r];
    end
    if (mv[1]) begin
      pm[addr1_r] <= {pm_rd_r[SB-1:0], samp1_r};
      if (par1_r) begin
        lb1[x1_r] <= col_cur;
      end else begin
        lb0[x1_r] <= col_cur;
      end
    end
  end

  assign col_cur = {samp1_r, pm_rd_r[SB-1:0], pm_rd_r[2*SB-1:SB]};
  assign col_old = par1_r ? lb1_rd_r : lb0_rd_r;
  assign col_mid = par1_r ? lb0_rd_r : lb1_rd_r;
  assign col_new = {col_cur, col_mid, col_old};

  assign ctl = '{shift: mv[1], load_a: mv[2], load_b: mv[3]};

  assign col_in[2] = col_new;
  assign col_in[1] = col_out[2];
  assign col_in[0] = col_out[1];

  for (genvar c = 0; c < 3; c++) begin : g_cell
    lv3d_cell #(.SB(SB)) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .col_in  (col_in[c]),
      .col_out (col_out[c]),
      .sum_f   (sum_f[c]),
      .sum_q   (sum_q[c])
    );
  end

  assign var_nxt = {sq6_r, 6'd0} - VW'($unsigned(msq_r));
  assign mean_w  = 64'(mean6_r);
  assign var_w   = 64'(var_nxt);

  always_ff @(posedge clk) begin
    if (mv[4]) begin
      mean5_r <= MW'(sum_f[0]) + (MW'(sum_f[1]) <<< 1) + MW'(sum_f[2]);
      sq5_r   <= QW'(sum_q[0]) + (QW'(sum_q[1]) << 1) + QW'(sum_q[2]);
    end
    if (mv[5]) begin
      mean6_r <= mean5_r;
      sq6_r   <= sq5_r;
      msq_r   <= mean5_r * mean5_r;
    end
    if (mv[6]) begin
      out_mean_scaled     <= mean_w[21:0];
      out_variance_scaled <= var_w[42:0];
      out_last_cell       <= lst_r[6];
    end
  end

  assign out_valid = out_valid_r;

  a_pos_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    XS'(pos_x_r) < sx) else $error("x position beyond row length");

  a_plane_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (mv[0] && mv[1]) |-> (addr0 != addr1_r)) else $error("plane store read/write collision");

  a_var_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[6] |-> ({sq6_r, 6'd0} >= VW'($unsigned(msq_r)))) else $error("negative variance");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v_r[1] && !free[2])) else $error("input stalled with stage 1 free");

  a_last_on_word: assert property (@(posedge clk) disable iff (!rst_n)
    mv[6] |=> out_valid_r) else $error("result word lost at output register");

endmodule

`default_nettype wire
